FILE: hdl/per_client_sequence_checker_defines.svh
// assertion macros for the sequence checker
`ifndef PER_CLIENT_SEQUENCE_CHECKER_DEFINES_SVH
`define PER_CLIENT_SEQUENCE_CHECKER_DEFINES_SVH

`ifndef SYNTH

// clocked check, switched off while reset is asserted
`define PCSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define PCSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PCSC_ASSERT(label, clk, rst_n, prop, msg)
`define PCSC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: hdl/pcsc_pkg.sv
package pcsc_pkg;

    localparam int CLIENT_SLOTS = 16;
    localparam int IDX_W        = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int COUNT_W      = $clog2(CLIENT_SLOTS + 1);

    localparam logic [7:0] FIRST_SEG = 8'd1;

    typedef enum logic [2:0] {
        CODE_NONE         = 3'd0,
        CODE_OUT_OF_SEQ   = 3'd1,
        CODE_DUPLICATE    = 3'd2,
        CODE_LEN_MISMATCH = 3'd3,
        CODE_END_MISSING  = 3'd4,
        CODE_TABLE_FULL   = 3'd5
    } t_code;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_VERDICT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0]  sender_id;
        logic [7:0]  seg_num;
        logic [7:0]  declared_length;
        logic [7:0]  payload_length;
        logic [15:0] end_marker;
    } t_item;

    typedef struct packed {
        logic       accepted;
        t_code      reject_code;
        logic [7:0] echo_client;
        logic [7:0] echo_seg;
    } t_result;

    typedef struct packed {
        logic [7:0] owner;
        logic [7:0] last_seg;
    } t_slot;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_slot            slot;
    } t_tbl_wr;

    // handshake between the sequencer and the stream wrapper
    typedef struct packed {
        logic ready;
        logic res_valid;
    } t_ctrl_status;

endpackage

FILE: hdl/per_client_sequence_checker.sv
// per-client packet sequence checker
// slave stream: one packet header per transfer; the block looks the client up
// in a 16-slot table, filled in arrival order and never freed, then checks
// sequence, length and end marker and emits one verdict per header on the
// master stream (accept flag, reject code, echoed client id and segment).
// config channel: one 16-bit write sets the expected end marker; always ready.
// scan: after a header is taken the sequencer reads the filled slots one per
// cycle through a single registered table port and one comparator, stopping
// at the first match; client zero and an empty table skip the scan. the
// verdict is registered in the sequencer and moves into the output register
// once that register is empty or being read. the slave side is ready again
// once the verdict has moved into the output register, so a header can be
// taken while the previous verdict still waits on the master side.
// if the receiver stalls, the verdict holds in the output register and a
// second finished verdict waits inside the sequencer, which then stops taking
// headers. reset empties the table and clears the end marker to zero; no
// clearing pass is run.
module per_client_sequence_checker
    import pcsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // sender_id[7:0], seg_num[15:8], declared_length[23:16],
    // payload_length[31:24], end_marker[47:32]
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // accepted[0], reject_code[3:1], echo_client[11:4], echo_seg[19:12], zero[23:20]
    output logic [23:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]  r_end_marker;
    logic         r_out_valid;
    t_result      r_out;
    t_item        item;
    t_ctrl_status status;
    t_result      result;
    logic         start;
    logic         res_taken;

    assign item.sender_id       = i_s_axis_tdata[7:0];
    assign item.seg_num         = i_s_axis_tdata[15:8];
    assign item.declared_length = i_s_axis_tdata[23:16];
    assign item.payload_length  = i_s_axis_tdata[31:24];
    assign item.end_marker      = i_s_axis_tdata[47:32];

    assign o_s_axis_tready = status.ready;
    assign start           = i_s_axis_tvalid && status.ready;
    assign res_taken       = status.res_valid && (!r_out_valid || i_m_axis_tready);
    assign o_cfg_ready     = 1'b1;

    pcsc_seq_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_item           (item),
        .i_end_marker_cfg (r_end_marker),
        .i_res_taken      (res_taken),
        .o_status         (status),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_end_marker <= i_cfg_data;
            end
            if (res_taken) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_taken) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out.echo_seg, r_out.echo_client,
                              r_out.reject_code, r_out.accepted};

endmodule

FILE: hdl/pcsc_slot_table.sv
module pcsc_slot_table
    import pcsc_pkg::*;
(
    input  logic             i_clk,
    input  t_tbl_wr          i_wr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_slot            o_rd_slot
);

    t_slot r_mem [CLIENT_SLOTS];
    t_slot r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.slot;
        end
        r_rd_slot <= r_mem[i_rd_addr];
    end

    assign o_rd_slot = r_rd_slot;

endmodule

FILE: hdl/pcsc_seq_ctrl.sv
`include "per_client_sequence_checker_defines.svh"

module pcsc_seq_ctrl
    import pcsc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_item        i_item,
    input  logic [15:0]  i_end_marker_cfg,
    input  logic         i_res_taken,
    output t_ctrl_status o_status,
    output t_result      o_result
);

    t_state               r_state, n_state;
    t_item                r_item;
    logic [COUNT_W-1:0]   r_rd_idx;
    logic                 r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [7:0]           r_hit_last;
    logic [COUNT_W-1:0]   r_slots_used, n_slots_used;
    t_result              r_result;

    t_slot                rd_slot;
    t_tbl_wr              tbl_wr;
    logic                 rd_issue;
    logic                 cmp_hit;
    logic                 scan_end;
    logic [8:0]           next_seg;
    t_code                seq_code;
    t_code                final_code;
    logic                 seq_wr;

    pcsc_slot_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_slot (rd_slot)
    );

    // shared compare unit: one stored owner against the captured client per cycle
    assign cmp_hit  = r_cmp_valid && (rd_slot.owner == r_item.sender_id);
    assign scan_end = !r_cmp_valid && (r_rd_idx >= r_slots_used);
    assign rd_issue = (r_state == S_SCAN) && (r_rd_idx < r_slots_used);

    // no wrap: after 255 every number is a duplicate
    assign next_seg = {1'b0, r_hit_last} + 9'd1;

    always_comb begin
        seq_code = CODE_NONE;
        seq_wr   = 1'b0;
        if (r_hit) begin
            if ({1'b0, r_item.seg_num} == next_seg) begin
                seq_wr = 1'b1;
            end else if ({1'b0, r_item.seg_num} > next_seg) begin
                seq_code = CODE_OUT_OF_SEQ;
            end else begin
                seq_code = CODE_DUPLICATE;
            end
        end else begin
            priority if (r_item.seg_num != FIRST_SEG) begin
                seq_code = CODE_OUT_OF_SEQ;
            end else if (r_item.sender_id == 8'd0) begin
                seq_code = CODE_NONE;
            end else if (r_slots_used >= COUNT_W'(CLIENT_SLOTS)) begin
                seq_code = CODE_TABLE_FULL;
            end else begin
                seq_wr = 1'b1;
            end
        end

        priority if (r_item.end_marker != i_end_marker_cfg) begin
            final_code = CODE_END_MISSING;
        end else if (r_item.declared_length != r_item.payload_length) begin
            final_code = CODE_LEN_MISMATCH;
        end else begin
            final_code = seq_code;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.sender_id == 8'd0 || r_slots_used == '0) begin
                        n_state = S_VERDICT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (cmp_hit || scan_end) begin
                    n_state = S_VERDICT;
                end
            end
            S_VERDICT: n_state = S_DONE;
            S_DONE: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_status.ready     = (r_state == S_IDLE);
        o_status.res_valid = (r_state == S_DONE);
        n_cmp_valid        = rd_issue && !cmp_hit;
        n_slots_used       = r_slots_used;
        tbl_wr.en          = 1'b0;
        tbl_wr.addr        = r_hit ? r_hit_idx : r_slots_used[IDX_W-1:0];
        tbl_wr.slot.owner    = r_item.sender_id;
        tbl_wr.slot.last_seg = r_item.seg_num;
        if (r_state == S_VERDICT && seq_wr) begin
            tbl_wr.en = 1'b1;
            if (!r_hit) begin
                n_slots_used = r_slots_used + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmp_valid  <= 1'b0;
            r_slots_used <= '0;
        end else begin
            r_state      <= n_state;
            r_cmp_valid  <= n_cmp_valid;
            r_slots_used <= n_slots_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_item   <= i_item;
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
        end
        if (rd_issue) begin
            r_rd_idx  <= r_rd_idx + COUNT_W'(1);
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (r_state == S_SCAN && cmp_hit) begin
            r_hit      <= 1'b1;
            r_hit_idx  <= r_cmp_idx;
            r_hit_last <= rd_slot.last_seg;
        end
        if (r_state == S_VERDICT) begin
            r_result.accepted    <= (final_code == CODE_NONE);
            r_result.reject_code <= final_code;
            r_result.echo_client <= r_item.sender_id;
            r_result.echo_seg    <= r_item.seg_num;
        end
    end

    assign o_result = r_result;

    `PCSC_ASSERT(a_used_bound, i_clk, i_rst_n, r_slots_used <= COUNT_W'(CLIENT_SLOTS), "slot count above table depth")
    `PCSC_ASSERT(a_wr_in_verdict, i_clk, i_rst_n, tbl_wr.en |-> (r_state == S_VERDICT), "table written outside verdict")
    `PCSC_ASSERT(a_start_idle, i_clk, i_rst_n, (i_start && r_state != S_IDLE) |=> (r_state != S_SCAN || $past(r_state) == S_SCAN), "item taken while busy")
    `PCSC_ASSERT(a_used_step, i_clk, i_rst_n, (r_slots_used != $past(r_slots_used)) |-> (r_slots_used == $past(r_slots_used) + COUNT_W'(1)), "slot count jumped")
    `PCSC_ASSERT(a_wr_client0, i_clk, i_rst_n, (tbl_wr.en && !r_hit) |-> (r_item.sender_id != 8'd0), "client zero recorded")

endmodule

FILE: test/per_client_sequence_checker_tb.sv
`timescale 1ns / 1ps

module per_client_sequence_checker_tb;
    import pcsc_pkg::*;

    localparam logic [7:0] HOT_CLIENT  = 8'd5;
    localparam int         STALL_LIMIT = 4000;

    // per-client sequence state plus the verdicts still owed by the block
    class verdict_tracker;
        logic [7:0]  owner [CLIENT_SLOTS];
        logic [7:0]  last_seg [CLIENT_SLOTS];
        int unsigned used;
        logic [15:0] end_marker;
        t_result     owed_verdicts[$];
        int unsigned errors;

        function new();
            used       = 0;
            end_marker = 16'h0000;
            errors     = 0;
        endfunction

        function int find_client(logic [7:0] id);
            if (id == 8'd0) begin
                return -1;
            end
            for (int i = 0; i < used; i++) begin
                if (owner[i] == id) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function t_code sequence_check(logic [7:0] id, logic [7:0] seg);
            int         s;
            logic [8:0] follow;
            s = find_client(id);
            if (s < 0) begin
                if (seg != FIRST_SEG) begin
                    return CODE_OUT_OF_SEQ;
                end
                if (id == 8'd0) begin
                    return CODE_NONE;
                end
                if (used >= CLIENT_SLOTS) begin
                    return CODE_TABLE_FULL;
                end
                owner[used]    = id;
                last_seg[used] = FIRST_SEG;
                used++;
                return CODE_NONE;
            end
            // no wrap: once 255 is stored every number is a duplicate
            follow = {1'b0, last_seg[s]} + 9'd1;
            if ({1'b0, seg} == follow) begin
                last_seg[s] = seg;
                return CODE_NONE;
            end
            if ({1'b0, seg} > follow) begin
                return CODE_OUT_OF_SEQ;
            end
            return CODE_DUPLICATE;
        endfunction

        function void note_header(logic [47:0] hdr);
            t_result verdict;
            t_code   code;
            code = sequence_check(hdr[7:0], hdr[15:8]);
            if (hdr[23:16] != hdr[31:24]) begin
                code = CODE_LEN_MISMATCH;
            end
            if (hdr[47:32] != end_marker) begin
                code = CODE_END_MISSING;
            end
            verdict.accepted    = (code == CODE_NONE);
            verdict.reject_code = code;
            verdict.echo_client = hdr[7:0];
            verdict.echo_seg    = hdr[15:8];
            owed_verdicts.push_back(verdict);
        endfunction

        function int pending();
            return owed_verdicts.size();
        endfunction

        function void check_verdict(logic [23:0] word);
            t_result want;
            t_result got;
            got.accepted    = word[0];
            got.reject_code = t_code'(word[3:1]);
            got.echo_client = word[11:4];
            got.echo_seg    = word[19:12];
            if (owed_verdicts.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected verdict: acc=%0d code=%0d client=%0d seg=%0d",
                             got.accepted, got.reject_code, got.echo_client, got.echo_seg);
                end
                return;
            end
            want = owed_verdicts.pop_front();
            if (got.accepted !== want.accepted || got.reject_code !== want.reject_code ||
                    got.echo_client !== want.echo_client || got.echo_seg !== want.echo_seg) begin
                errors++;
                if (errors <= 10) begin
                    $display("verdict mismatch: expected acc=%0d code=%0d client=%0d seg=%0d",
                             want.accepted, want.reject_code, want.echo_client, want.echo_seg);
                    $display("                  got      acc=%0d code=%0d client=%0d seg=%0d",
                             got.accepted, got.reject_code, got.echo_client, got.echo_seg);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int             s_idle = 15;
    int             m_idle = 75;
    int             stall_cycles = 0;
    verdict_tracker book = new();

    per_client_sequence_checker uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [47:0] pack_header(logic [7:0] id, logic [7:0] seg,
                                                logic [7:0] decl, logic [7:0] meas,
                                                logic [15:0] endm);
        return {endm, meas, decl, seg, id};
    endfunction

    // mostly well-formed continuations of known sequences, some broken, some noise
    function automatic logic [47:0] next_header();
        int          roll;
        int          pick;
        int          s;
        logic [7:0]  pool_id;
        logic [7:0]  id;
        logic [7:0]  seg;
        logic [7:0]  decl;
        logic [7:0]  meas;
        logic [15:0] endm;
        pick    = $urandom_range(0, 23);
        pool_id = (pick == 23) ? 8'hFF : 8'(pick);
        if ($urandom_range(0, 99) < 35) begin
            pool_id = HOT_CLIENT;
        end
        decl = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            id   = pool_id;
            s    = book.find_client(id);
            meas = decl;
            endm = book.end_marker;
            if (s < 0) begin
                seg = FIRST_SEG;
            end else if (book.last_seg[s] == 8'hFF) begin
                seg = 8'($urandom);
            end else begin
                seg = book.last_seg[s] + 8'd1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                seg = 8'($urandom);
            end else if (roll < 14) begin
                meas = decl ^ 8'($urandom_range(1, 255));
            end else if (roll < 20) begin
                endm = endm ^ 16'($urandom_range(1, 65535));
            end
        end else begin
            id   = $urandom_range(0, 1) ? pool_id : 8'($urandom);
            seg  = 8'($urandom);
            meas = $urandom_range(0, 1) ? decl : 8'($urandom);
            endm = $urandom_range(0, 1) ? book.end_marker : 16'($urandom);
        end
        return pack_header(id, seg, decl, meas, endm);
    endfunction

    task automatic send_header(input logic [47:0] hdr);
        if ($urandom_range(0, 99) < s_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < s_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hdr;
        do @(posedge clk); while (!s_tready);
        book.note_header(hdr);
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            send_header(next_header());
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_marker(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.end_marker = value;
    endtask

    task automatic wait_drained();
        while (book.pending() != 0) begin
            @(posedge clk);
        end
    endtask

    // result side: check on each transfer, then pick the next ready
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            book.check_verdict(m_tdata);
        end
        m_tready <= ($urandom_range(0, 99) >= m_idle);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("per_client_sequence_checker_tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_marker(16'h0000);

        // client zero, unknown clients, duplicates, gaps, stored-despite-reject,
        // length and marker precedence, field extremes
        send_header(pack_header(8'd0, 8'd1, 8'd0, 8'd0, 16'h0000));
        send_header(pack_header(8'd0, 8'd2, 8'd0, 8'd0, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd3, 8'd1, 8'd1, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd1, 8'd255, 8'd255, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd2, 8'd4, 8'd4, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd2, 8'd4, 8'd4, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd0, 8'd4, 8'd4, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd200, 8'd4, 8'd4, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd3, 8'd10, 8'd11, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd4, 8'd7, 8'd7, 16'hFFFF));
        send_header(pack_header(HOT_CLIENT, 8'd5, 8'd0, 8'd255, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd6, 8'd0, 8'd0, 16'h0000));
        send_header(pack_header(HOT_CLIENT, 8'd7, 8'd3, 8'd4, 16'hFFFF));
        send_header(pack_header(8'd255, 8'd1, 8'd255, 8'd255, 16'h0000));
        send_header(pack_header(8'd255, 8'd255, 8'd9, 8'd9, 16'h0000));
        send_header(pack_header(8'd255, 8'd1, 8'd9, 8'd9, 16'h0000));
        send_header(pack_header(8'd255, 8'd2, 8'hAA, 8'hAA, 16'h8000));
        send_header(pack_header(8'd0, 8'd1, 8'd1, 8'd1, 16'h0001));
        send_header(pack_header(8'd7, 8'd1, 8'd12, 8'd12, 16'h0000));
        send_header(pack_header(8'd7, 8'd7, 8'd12, 8'd12, 16'h0000));
        s_tvalid <= 1'b0;
        wait_drained();

        write_marker(16'hFFFF);
        send_random(560);
        wait_drained();

        s_idle = 75;
        m_idle = 15;
        write_marker(16'($urandom));
        send_random(560);
        wait_drained();

        s_idle = 0;
        m_idle = 0;
        write_marker(16'h0000);
        send_random(560);
        wait_drained();

        repeat (25) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("per_client_sequence_checker_tb: done, clean");
        end else begin
            $display("per_client_sequence_checker_tb: done, errors");
        end
        $finish;
    end

endmodule
